// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/ttgc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttgc_pkg
// shared types and constants of the touch tap gesture classifier
// ----------------------------------------------------------------------------
`default_nettype none

package ttgc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned CLICK_W = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_RELEASE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_REENTER       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_ENABLE      = 2'd2;

    localparam logic [LIMIT_W-1:0] RST_TAP_RELEASE_LIMIT = 16'd200;
    localparam logic [LIMIT_W-1:0] RST_TAP_REENTER       = 16'd250;
    localparam logic               RST_TOUCH_ENABLE      = 1'b1;

    localparam logic [COUNT_W-1:0] TAP_COUNT_MAX = 16'hFFFF;

    typedef enum logic [CLICK_W-1:0] {
        CLICK_NONE   = 2'd0,
        CLICK_LEFT   = 2'd1,
        CLICK_RIGHT  = 2'd2,
        CLICK_MIDDLE = 2'd3
    } t_click;

endpackage

`default_nettype wire

// ===== design/touch_tap_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// touch_tap_gesture_classifier
// classifies per-frame touch samples into left, right and middle clicks
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tdata: now_ms[31:0], touch_now[32], motion_seen[33]
//  m_axis    | out       | tdata: click_button[1:0], taps_pending[17:2], touching[18]
//  cfg       | in        | write enable, register index, 16-bit write data
//
//  one transaction per cycle in while the output is not stalled, one result per transaction out
//  the result is captured in the output register at acceptance
//  the state update is a single compare-and-update pass at acceptance
//  input is taken whenever the output register is empty or being drained
//  synchronous active-low reset restores register defaults and clears state
// ----------------------------------------------------------------------------
`default_nettype none

module touch_tap_gesture_classifier
    import ttgc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output      logic                  o_s_axis_tready,
    // now_ms, touch_now, motion_seen, zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output      logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // click_button, taps_pending, touching, zero pad
    output      logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [LIMIT_W-1:0] r_release_limit;
    logic [LIMIT_W-1:0] r_reenter;
    logic               r_enable;

    logic [TIME_W-1:0]  r_press_time,   n_press_time;
    logic [TIME_W-1:0]  r_release_time, n_release_time;
    logic [COUNT_W-1:0] r_count,        n_count;
    logic               r_pressed,      n_pressed;
    logic               r_drag,         n_drag;

    logic               r_out_valid;
    t_click             r_click,        n_click;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_touching;

    logic [TIME_W-1:0]  now_ms;
    logic               touch_now;
    logic               motion_seen;
    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  idle;
    logic               accept;

    assign now_ms      = i_s_axis_tdata[TIME_W-1:0];
    assign touch_now   = i_s_axis_tdata[TIME_W];
    assign motion_seen = i_s_axis_tdata[TIME_W+1];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign held = now_ms - r_press_time;
    assign idle = now_ms - n_release_time;

    always_comb begin
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        n_count        = r_count;
        n_pressed      = r_pressed;
        n_drag         = r_drag;
        n_click        = CLICK_NONE;

        // touch edges
        if (r_enable) begin
            if (touch_now && !r_pressed) begin
                n_press_time = now_ms;
                n_drag       = 1'b0;
                n_pressed    = 1'b1;
            end else if (!touch_now && r_pressed) begin
                n_release_time = now_ms;
                n_pressed      = 1'b0;
                if (!r_drag && (held < {{(TIME_W-LIMIT_W){1'b0}}, r_release_limit})) begin
                    if (r_count != TAP_COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_count = '0;
                end
            end
        end

        // flush pending taps
        if (!n_pressed && (n_count != '0)) begin
            if (idle > {{(TIME_W-LIMIT_W){1'b0}}, r_reenter}) begin
                case (n_count)
                    16'd1:   n_click = CLICK_LEFT;
                    16'd2:   n_click = CLICK_RIGHT;
                    default: n_click = CLICK_MIDDLE;
                endcase
                n_count = '0;
            end
        end

        // drag check
        if (r_enable && touch_now && n_pressed && motion_seen) begin
            n_drag  = 1'b1;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_limit <= RST_TAP_RELEASE_LIMIT;
            r_reenter       <= RST_TAP_REENTER;
            r_enable        <= RST_TOUCH_ENABLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TAP_RELEASE_LIMIT: r_release_limit <= i_cfg_data;
                REG_TAP_REENTER:       r_reenter       <= i_cfg_data;
                REG_TOUCH_ENABLE:      r_enable        <= i_cfg_data[0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_time   <= '0;
            r_release_time <= '0;
            r_count        <= '0;
            r_pressed      <= 1'b0;
            r_drag         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_press_time   <= n_press_time;
                r_release_time <= n_release_time;
                r_count        <= n_count;
                r_pressed      <= n_pressed;
                r_drag         <= n_drag;
                r_out_valid    <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_click        <= n_click;
            r_out_count    <= n_count;
            r_out_touching <= n_pressed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-CLICK_W-COUNT_W-1){1'b0}},
                              r_out_touching, r_out_count, r_click};

endmodule

`default_nettype wire

// ===== design/ttgc_checker.sv =====
// ----------------------------------------------------------------------------
// ttgc_checker
// port-level assertions for the touch tap gesture classifier
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ttgc_checker
    import ttgc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic               in_xfer;
    logic               out_stall;
    logic               click_any;
    logic [COUNT_W-1:0] out_count;
    logic               out_touching;

    assign in_xfer      = i_s_axis_tvalid && o_s_axis_tready;
    assign out_stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign click_any    = o_m_axis_tdata[CLICK_W-1:0] != CLICK_NONE;
    assign out_count    = o_m_axis_tdata[CLICK_W+COUNT_W-1:CLICK_W];
    assign out_touching = o_m_axis_tdata[CLICK_W+COUNT_W];

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // every accepted transaction shows up next cycle
    `ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, in_xfer, o_m_axis_tvalid)
    // empty output stage never blocks input
    `ASSERT_IMPLY(a_ready_empty, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    // a click empties the tap count and happens only while released
    `ASSERT_IMPLY(a_click_clear, i_clk, i_rst_n, o_m_axis_tvalid && click_any,
        (out_count == '0) && !out_touching)

endmodule

bind touch_tap_gesture_classifier ttgc_checker u_ttgc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== test/tb_touch_tap_gesture_classifier.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touch_tap_gesture_classifier
// self-checking bench for the touch tap gesture classifier
// ----------------------------------------------------------------------------
//  frames go in on the input stream. A behavioral copy of the tap logic
//  predicts each result, and every result transaction is compared with the
//  oldest prediction. Directed tests cover the click kinds, the boundaries of
//  both time limits, drags, long presses, wrapping and backward timestamps
//  and disabled touch. The random tests then run
//  well-formed tap bursts mixed with noise under several register settings.
//  Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_touch_tap_gesture_classifier;
    import ttgc_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_FRAMES = 1650;
    localparam int unsigned PHASE_COUNT   = 8;
    localparam int unsigned PAD_W         = IN_DATA_W - TIME_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        t_click             click;
        logic [COUNT_W-1:0] taps;
        logic               touching;
    } t_frame_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    // now_ms, touch_now, motion_seen, zero pad
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // click_button, taps_pending, touching, zero pad
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // shadow registers and gesture state
    logic [LIMIT_W-1:0] cfg_limit;
    logic [LIMIT_W-1:0] cfg_reenter;
    logic               cfg_enable;
    logic [TIME_W-1:0]  press_ms;
    logic [TIME_W-1:0]  release_ms;
    logic [COUNT_W-1:0] tap_total;
    logic               is_pressed;
    logic               is_drag;

    t_frame_result      expected_frames[$];
    t_frame_result      oldest_frame;
    int unsigned        fail_count;
    int unsigned        frames_sent;
    int unsigned        cycle_count;
    int unsigned        ready_stall;
    logic               flow_quiet;
    logic [TIME_W-1:0]  clock_ms;

    logic [LIMIT_W-1:0]    phase_limit[PHASE_COUNT]   = '{16'd200, 16'd0, 16'd65535, 16'd1,
                                                          16'd30, 16'd0, 16'd60, 16'd100};
    logic [LIMIT_W-1:0]    phase_reenter[PHASE_COUNT] = '{16'd250, 16'd0, 16'd65535, 16'd0,
                                                          16'd20, 16'd0, 16'd65535, 16'd50};
    logic [CFG_DATA_W-1:0] phase_enable[PHASE_COUNT]  = '{16'h0001, 16'h0001, 16'h0001, 16'hFFFF,
                                                          16'h0001, 16'h0001, 16'h0001, 16'h0002};

    touch_tap_gesture_classifier u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (flow_quiet || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [TIME_W-1:0] near_bound(input logic [TIME_W-1:0] bound);
        case ($urandom_range(0, 3))
            0:       return bound - 1;
            1:       return bound;
            2:       return bound + 1;
            default: return $urandom_range(0, bound);
        endcase
    endfunction

    // edge handling, then pending tap flush, then drag check
    function automatic t_frame_result classify_frame(input logic [TIME_W-1:0] now_ms,
                                                     input logic touch_now,
                                                     input logic motion_seen);
        t_frame_result     res;
        logic [TIME_W-1:0] held_ms;
        logic [TIME_W-1:0] idle_ms;
        res.click = CLICK_NONE;
        if (cfg_enable) begin
            if (touch_now && !is_pressed) begin
                press_ms   = now_ms;
                is_drag    = 1'b0;
                is_pressed = 1'b1;
            end else if (!touch_now && is_pressed) begin
                held_ms    = now_ms - press_ms;
                release_ms = now_ms;
                is_pressed = 1'b0;
                if (!is_drag && held_ms < {16'd0, cfg_limit}) begin
                    if (tap_total != TAP_COUNT_MAX)
                        tap_total = tap_total + 1'b1;
                end else begin
                    tap_total = '0;
                end
            end
        end
        idle_ms = now_ms - release_ms;
        if (!is_pressed && tap_total != '0 && idle_ms > {16'd0, cfg_reenter}) begin
            case (tap_total)
                16'd1:   res.click = CLICK_LEFT;
                16'd2:   res.click = CLICK_RIGHT;
                default: res.click = CLICK_MIDDLE;
            endcase
            tap_total = '0;
        end
        if (cfg_enable && touch_now && is_pressed && motion_seen) begin
            is_drag   = 1'b1;
            tap_total = '0;
        end
        res.taps     = tap_total;
        res.touching = is_pressed;
        return res;
    endfunction

    task automatic send_frame(input logic [TIME_W-1:0] now_ms, input logic touch_now,
                              input logic motion_seen);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{PAD_W{1'b0}}, motion_seen, touch_now, now_ms};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_frames.push_back(classify_frame(now_ms, touch_now, motion_seen));
        frames_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_TAP_RELEASE_LIMIT: cfg_limit   = value;
            REG_TAP_REENTER:       cfg_reenter = value;
            REG_TOUCH_ENABLE:      cfg_enable  = value[0];
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin
        if (ready_stall != 0 && !flow_quiet) begin
            i_m_axis_tready <= 1'b0;
            ready_stall = ready_stall - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            ready_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_frames.size() == 0) begin
                $error("result transaction with no frame pending: data %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                oldest_frame = expected_frames.pop_front();
                if (o_m_axis_tdata[1:0] !== oldest_frame.click) begin
                    $error("click_button mismatch: expected %0d, actual %0d",
                           oldest_frame.click, o_m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[17:2] !== oldest_frame.taps) begin
                    $error("taps_pending mismatch: expected %0d, actual %0d",
                           oldest_frame.taps, o_m_axis_tdata[17:2]);
                    fail_count++;
                end
                if (o_m_axis_tdata[18] !== oldest_frame.touching) begin
                    $error("touching mismatch: expected %0d, actual %0d",
                           oldest_frame.touching, o_m_axis_tdata[18]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_tap_counts();
        // single tap
        send_frame(32'd1000, 1'b1, 1'b0);
        send_frame(32'd1100, 1'b0, 1'b0);
        send_frame(32'd1400, 1'b0, 1'b0);
        // double tap
        send_frame(32'd2000, 1'b1, 1'b0);
        send_frame(32'd2050, 1'b0, 1'b0);
        send_frame(32'd2100, 1'b1, 1'b0);
        send_frame(32'd2150, 1'b0, 1'b0);
        send_frame(32'd2500, 1'b0, 1'b0);
        // triple tap, last hold one below the limit, idle exactly at the limit then past it
        send_frame(32'd3000, 1'b1, 1'b0);
        send_frame(32'd3010, 1'b0, 1'b0);
        send_frame(32'd3020, 1'b1, 1'b0);
        send_frame(32'd3030, 1'b0, 1'b0);
        send_frame(32'd3040, 1'b1, 1'b0);
        send_frame(32'd3239, 1'b0, 1'b0);
        send_frame(32'd3489, 1'b0, 1'b0);
        send_frame(32'd3490, 1'b0, 1'b0);
    endtask

    task automatic test_drag_and_long_press();
        // motion in the press frame clears a pending tap
        send_frame(32'd3900, 1'b1, 1'b0);
        send_frame(32'd3950, 1'b0, 1'b0);
        send_frame(32'd4000, 1'b1, 1'b1);
        send_frame(32'd4010, 1'b0, 1'b0);
        // hold equal to the limit is not a tap
        send_frame(32'd4800, 1'b1, 1'b0);
        send_frame(32'd4850, 1'b0, 1'b0);
        send_frame(32'd5000, 1'b1, 1'b0);
        send_frame(32'd5200, 1'b0, 1'b0);
        // motion with no touch
        send_frame(32'd5300, 1'b0, 1'b1);
    endtask

    task automatic test_time_wrap();
        send_frame(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_frame(32'h0000_0010, 1'b0, 1'b0);
        send_frame(32'h0000_0200, 1'b0, 1'b0);
        // release stamped before the press
        send_frame(32'h0000_0300, 1'b1, 1'b0);
        send_frame(32'h0000_0100, 1'b0, 1'b0);
    endtask

    task automatic test_touch_disable();
        send_frame(32'd6000, 1'b1, 1'b0);
        drain_results();
        write_reg(REG_TOUCH_ENABLE, 16'hFFFE);
        send_frame(32'd6010, 1'b0, 1'b1);
        send_frame(32'd6020, 1'b1, 1'b1);
        drain_results();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_TOUCH_ENABLE, 16'h0001);
        send_frame(32'd6050, 1'b0, 1'b0);
        drain_results();
        // flush still runs with touch disabled
        write_reg(REG_TOUCH_ENABLE, 16'h0000);
        send_frame(32'd6400, 1'b0, 1'b0);
        drain_results();
        write_reg(REG_TOUCH_ENABLE, 16'h0001);
    endtask

    task automatic run_tap_burst();
        int unsigned       tap_n;
        int unsigned       mid_n;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] gap_ms;
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] last_release;
        tap_n        = $urandom_range(1, 4);
        last_release = clock_ms;
        flow_quiet   = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < tap_n; k++) begin
            hold_ms  = near_bound({16'd0, cfg_limit});
            start_ms = clock_ms;
            send_frame(start_ms, 1'b1, $urandom_range(0, 15) == 0);
            mid_n = $urandom_range(0, 2);
            for (int j = 1; j <= mid_n; j++)
                send_frame(start_ms + hold_ms / (mid_n + 1) * j, 1'b1, $urandom_range(0, 7) == 0);
            clock_ms = start_ms + hold_ms;
            send_frame(clock_ms, 1'b0, $urandom_range(0, 7) == 0);
            last_release = clock_ms;
            if ($urandom_range(0, 3) == 0)
                gap_ms = near_bound({16'd0, cfg_reenter});
            else
                gap_ms = $urandom_range(0, cfg_reenter / 2);
            if ($urandom_range(0, 1))
                send_frame(clock_ms + gap_ms / 2, 1'b0, 1'b0);
            clock_ms = clock_ms + gap_ms;
        end
        clock_ms = last_release + near_bound({16'd0, cfg_reenter});
        send_frame(clock_ms, 1'b0, 1'b0);
        clock_ms = clock_ms + $urandom_range(1, 40);
        send_frame(clock_ms, 1'b0, 1'b0);
        flow_quiet = 1'b0;
    endtask

    task automatic test_random_gestures();
        int unsigned phase_end;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            if (p == 5) begin
                phase_limit[p]   = 16'($urandom_range(0, 400));
                phase_reenter[p] = 16'($urandom_range(0, 400));
            end
            write_reg(REG_TAP_RELEASE_LIMIT, phase_limit[p]);
            write_reg(REG_TAP_REENTER, phase_reenter[p]);
            write_reg(REG_TOUCH_ENABLE, phase_enable[p]);
            clock_ms  = $urandom;
            phase_end = frames_sent + RANDOM_FRAMES / PHASE_COUNT;
            while (frames_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    7: begin
                        repeat ($urandom_range(1, 3))
                            send_frame($urandom, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)));
                    end
                    8: begin
                        drain_results();
                        write_reg(REG_TOUCH_ENABLE,
                                  {15'($urandom_range(0, 32767)), ($urandom_range(0, 3) != 0)});
                    end
                    9: begin
                        clock_ms = clock_ms + $urandom_range(0, cfg_reenter + 10);
                        send_frame(clock_ms, 1'b0, 1'($urandom_range(0, 1)));
                    end
                    default: run_tap_burst();
                endcase
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_TAP_RELEASE_LIMIT;
        i_cfg_data      = '0;
        cfg_limit       = RST_TAP_RELEASE_LIMIT;
        cfg_reenter     = RST_TAP_REENTER;
        cfg_enable      = RST_TOUCH_ENABLE;
        press_ms        = '0;
        release_ms      = '0;
        tap_total       = '0;
        is_pressed      = 1'b0;
        is_drag         = 1'b0;
        fail_count      = 0;
        frames_sent     = 0;
        cycle_count     = 0;
        ready_stall     = 0;
        flow_quiet      = 1'b0;
        clock_ms        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_tap_counts();
        test_drag_and_long_press();
        test_time_wrap();
        test_touch_disable();
        test_random_gestures();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
